// ----- hdl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, constants and types for the rotation matrix to quaternion
// converter.
// -----------------------------------------------------------------------------
package rmq_pkg;

    localparam int Q_W       = 18;
    localparam int SUM_W     = 21;
    localparam int D_W       = 19;
    localparam int N_W       = 33;
    localparam int ROOT_W    = 17;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int NUM_W     = 34;
    localparam int DEN_W     = 18;
    localparam int QUO_W     = 18;
    localparam int DIV_STEPS = QUO_W;
    localparam int LANES     = 3;
    localparam int IN_W      = 168;
    localparam int OUT_W     = 4 * Q_W;

    localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(65536);
    localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'(131071);

    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;
    localparam logic [1:0] IDX_W = 2'd3;

    typedef struct packed {
        logic [1:0]       best;
        logic [LANES-1:0] neg;
    } tag_t;

endpackage

// ----- hdl/rotation_matrix_to_quaternion_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a 3x3 rotation matrix in signed Q2.16 to a quaternion by
// Shepperd's method, with a bit-per-stage square root and divider.
// -----------------------------------------------------------------------------
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid tready tdata[167:0]     m11..m33, 18 bits each
//  m_axis    out        tvalid tready tdata[71:0] tuser x, y, z, w; largest index
//
//  The pipeline has one pre stage, 17 square root stages, one setup
//  stage, 18 divider stages and the output register.
//  One item enters in every cycle while the output is taken.
//  The whole pipeline holds when a result waits on m_axis_tready.
//  Reset clears only the valid bits.
// -----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32, m33, zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [OUT_W-1:0] m_axis_tdata,
    // largest_index
    output logic [1:0]       m_axis_tuser
);

    logic adv;

    logic signed [SUM_W-1:0] a [9];
    logic signed [SUM_W-1:0] s_sum [4];
    logic signed [SUM_W-1:0] s_best;
    logic [1:0]              best_c;
    logic signed [D_W-1:0]   d_c [LANES];
    logic [D_W-1:0]          mag_c [LANES];
    logic [LANES-1:0]        neg_c;

    logic                    p_valid_reg;
    tag_t                    p_tag_reg;
    logic [N_W-1:0]          p_n_reg;
    logic [D_W-1:0]          p_mag_reg [LANES];

    logic                    sq_valid_reg [SQ_STEPS];
    tag_t                    sq_tag_reg   [SQ_STEPS];
    logic [N_W-1:0]          sq_rem_reg   [SQ_STEPS];
    logic [ROOT_W-1:0]       sq_root_reg  [SQ_STEPS];
    logic [D_W-1:0]          sq_mag_reg   [SQ_STEPS][LANES];
    logic [N_W-1:0]          sq_rem_next  [SQ_STEPS];
    logic [ROOT_W-1:0]       sq_root_next [SQ_STEPS];

    logic                    n_valid_reg;
    tag_t                    n_tag_reg;
    logic [ROOT_W-1:0]       n_v_reg;
    logic [NUM_W-1:0]        n_num_reg [LANES];

    logic                    dv_valid_reg [DIV_STEPS];
    tag_t                    dv_tag_reg   [DIV_STEPS];
    logic [ROOT_W-1:0]       dv_v_reg     [DIV_STEPS];
    logic [NUM_W-1:0]        dv_rem_reg   [DIV_STEPS][LANES];
    logic [QUO_W-1:0]        dv_q_reg     [DIV_STEPS][LANES];
    logic [NUM_W-1:0]        dv_rem_next  [DIV_STEPS][LANES];
    logic [QUO_W-1:0]        dv_q_next    [DIV_STEPS][LANES];

    logic [Q_W-1:0]          lane_val [LANES];
    logic [Q_W-1:0]          comp_c [4];

    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;
    logic [1:0]              out_idx_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_idx_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            a[i] = SUM_W'(signed'(s_axis_tdata[i*Q_W +: Q_W]));
        end
        s_sum[0] =  a[0] - a[4] - a[8] + Q_ONE;
        s_sum[1] = -a[0] + a[4] - a[8] + Q_ONE;
        s_sum[2] = -a[0] - a[4] + a[8] + Q_ONE;
        s_sum[3] =  a[0] + a[4] + a[8] + Q_ONE;
        best_c = IDX_X;
        s_best = s_sum[0];
        if (s_sum[1] > s_best)
        begin
            best_c = IDX_Y;
            s_best = s_sum[1];
        end
        if (s_sum[2] > s_best)
        begin
            best_c = IDX_Z;
            s_best = s_sum[2];
        end
        if (s_sum[3] > s_best)
        begin
            best_c = IDX_W;
            s_best = s_sum[3];
        end
        unique case (best_c)
            IDX_X:
            begin
                d_c[0] = D_W'(a[1] + a[3]);
                d_c[1] = D_W'(a[6] + a[2]);
                d_c[2] = D_W'(a[7] - a[5]);
            end
            IDX_Y:
            begin
                d_c[0] = D_W'(a[1] + a[3]);
                d_c[1] = D_W'(a[5] + a[7]);
                d_c[2] = D_W'(a[2] - a[6]);
            end
            IDX_Z:
            begin
                d_c[0] = D_W'(a[6] + a[2]);
                d_c[1] = D_W'(a[5] + a[7]);
                d_c[2] = D_W'(a[3] - a[1]);
            end
            default:
            begin
                d_c[0] = D_W'(a[7] - a[5]);
                d_c[1] = D_W'(a[2] - a[6]);
                d_c[2] = D_W'(a[3] - a[1]);
            end
        endcase
        for (int l = 0; l < LANES; l++)
        begin
            neg_c[l] = d_c[l][D_W-1];
            mag_c[l] = neg_c[l] ? D_W'(-d_c[l]) : D_W'(d_c[l]);
        end
    end

    // Square root, one result bit per stage: rem holds n - root^2.
    always_comb
    begin
        logic [N_W-1:0]    rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [N_W+1:0]    trial;
        for (int j = 0; j < SQ_STEPS; j++)
        begin
            rem_in  = (j == 0) ? p_n_reg : sq_rem_reg[(j == 0) ? 0 : j-1];
            root_in = (j == 0) ? '0 : sq_root_reg[(j == 0) ? 0 : j-1];
            trial   = ((N_W+2)'(root_in) << (SQ_STEPS - j))
                    + ((N_W+2)'(1) << (2 * (SQ_STEPS - 1 - j)));
            if ((N_W+2)'(rem_in) >= trial)
            begin
                sq_rem_next[j]  = rem_in - trial[N_W-1:0];
                sq_root_next[j] = root_in | (ROOT_W'(1) << (SQ_STEPS - 1 - j));
            end
            else
            begin
                sq_rem_next[j]  = rem_in;
                sq_root_next[j] = root_in;
            end
        end
    end

    // Restoring division of (mag * 32768 + v) by 2v, one quotient bit per stage.
    always_comb
    begin
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] q_in;
        logic [DEN_W-1:0] den;
        logic [NUM_W+1:0] trial;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            den = (j == 0) ? {n_v_reg, 1'b0} : {dv_v_reg[(j == 0) ? 0 : j-1], 1'b0};
            for (int l = 0; l < LANES; l++)
            begin
                rem_in = (j == 0) ? n_num_reg[l] : dv_rem_reg[(j == 0) ? 0 : j-1][l];
                q_in   = (j == 0) ? '0 : dv_q_reg[(j == 0) ? 0 : j-1][l];
                trial  = (NUM_W+2)'(den) << (DIV_STEPS - 1 - j);
                if ((NUM_W+2)'(rem_in) >= trial)
                begin
                    dv_rem_next[j][l] = rem_in - trial[NUM_W-1:0];
                    dv_q_next[j][l]   = q_in | (QUO_W'(1) << (DIV_STEPS - 1 - j));
                end
                else
                begin
                    dv_rem_next[j][l] = rem_in;
                    dv_q_next[j][l]   = q_in;
                end
            end
        end
    end

    always_comb
    begin
        logic [QUO_W-1:0] q;
        for (int l = 0; l < LANES; l++)
        begin
            q = dv_q_reg[DIV_STEPS-1][l];
            if (dv_tag_reg[DIV_STEPS-1].neg[l])
            begin
                lane_val[l] = Q_W'(-q);
            end
            else
            begin
                lane_val[l] = (q > Q_POS_MAX) ? Q_POS_MAX : q;
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            if (2'(c) == dv_tag_reg[DIV_STEPS-1].best)
            begin
                comp_c[c] = Q_W'(dv_v_reg[DIV_STEPS-1]);
            end
            else if (2'(c) < dv_tag_reg[DIV_STEPS-1].best)
            begin
                comp_c[c] = lane_val[(c < LANES) ? c : 0];
            end
            else
            begin
                comp_c[c] = lane_val[(c > 0) ? c-1 : 0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                sq_valid_reg[j] <= 1'b0;
            end
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            p_valid_reg     <= s_axis_tvalid;
            sq_valid_reg[0] <= p_valid_reg;
            for (int j = 1; j < SQ_STEPS; j++)
            begin
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            end
            n_valid_reg     <= sq_valid_reg[SQ_STEPS-1];
            dv_valid_reg[0] <= n_valid_reg;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
            out_valid_reg   <= dv_valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_tag_reg.best <= best_c;
            p_tag_reg.neg  <= neg_c;
            p_n_reg        <= {s_best[N_W-15:0], 14'b0};
            for (int l = 0; l < LANES; l++)
            begin
                p_mag_reg[l] <= mag_c[l];
            end

            for (int j = 0; j < SQ_STEPS; j++)
            begin
                sq_tag_reg[j]  <= (j == 0) ? p_tag_reg : sq_tag_reg[(j == 0) ? 0 : j-1];
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                for (int l = 0; l < LANES; l++)
                begin
                    sq_mag_reg[j][l] <= (j == 0) ? p_mag_reg[l]
                                                 : sq_mag_reg[(j == 0) ? 0 : j-1][l];
                end
            end

            n_tag_reg <= sq_tag_reg[SQ_STEPS-1];
            n_v_reg   <= sq_root_reg[SQ_STEPS-1];
            for (int l = 0; l < LANES; l++)
            begin
                n_num_reg[l] <= {sq_mag_reg[SQ_STEPS-1][l], 15'b0}
                              + NUM_W'(sq_root_reg[SQ_STEPS-1]);
            end

            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_tag_reg[j] <= (j == 0) ? n_tag_reg : dv_tag_reg[(j == 0) ? 0 : j-1];
                dv_v_reg[j]   <= (j == 0) ? n_v_reg : dv_v_reg[(j == 0) ? 0 : j-1];
                for (int l = 0; l < LANES; l++)
                begin
                    dv_rem_reg[j][l] <= dv_rem_next[j][l];
                    dv_q_reg[j][l]   <= dv_q_next[j][l];
                end
            end

            out_data_reg <= {comp_c[3], comp_c[2], comp_c[1], comp_c[0]};
            out_idx_reg  <= dv_tag_reg[DIV_STEPS-1].best;
        end
    end

endmodule

// ----- hdl/rmq_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion converter.
// -----------------------------------------------------------------------------
module rmq_checker
    import rmq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);

    // The input side moves exactly when the output side is free.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output state");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    // When x or w is chosen, that component is a square root of at least one half.
    a_x_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == IDX_X |->
            !m_axis_tdata[Q_W-1] && m_axis_tdata[Q_W-2:Q_W-3] != 2'b00)
        else $error("x root out of range");

    a_w_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == IDX_W |->
            !m_axis_tdata[4*Q_W-1] && m_axis_tdata[4*Q_W-2:4*Q_W-3] != 2'b00)
        else $error("w root out of range");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
